// File: src/lvrs_pkg.sv
package lvrs_pkg;

   // Widths of the configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ENABLED      = 3'd0,
      REG_START_MV     = 3'd1,
      REG_ABORT_MV     = 3'd2,
      REG_HYSTERESIS   = 3'd3,
      REG_MIN_LOW_SEC  = 3'd4,
      REG_MAX_ATTEMPTS = 3'd5,
      REG_MIN_GAP_SEC  = 3'd6,
      REG_PROGRAM      = 3'd7
   } csr_index_type;

   // Register values after reset
   localparam logic [15:0] START_MV_RESET     = 16'd12000;
   localparam logic [15:0] ABORT_MV_RESET     = 16'd11000;
   localparam logic [15:0] HYSTERESIS_RESET   = 16'd300;
   localparam logic [15:0] MIN_LOW_SEC_RESET  = 16'd60;
   localparam logic [7:0]  MAX_ATTEMPTS_RESET = 8'd3;
   localparam logic [15:0] MIN_GAP_SEC_RESET  = 16'd3600;
   localparam logic [7:0]  PROGRAM_RESET      = 8'd0;

   // Seconds are turned into milliseconds once, at the register write
   localparam logic [9:0] MS_PER_SEC = 10'd1000;

   // Programmed settings, with the two durations kept in milliseconds
   typedef struct packed {
      logic        enabled;
      logic [15:0] start_mv;
      logic [15:0] abort_mv;
      logic [15:0] hysteresis_mv;
      logic [31:0] min_low_ms;
      logic [7:0]  max_attempts;
      logic [31:0] min_gap_ms;
      logic [7:0]  program_number;
   } cfg_type;

   // One sample beat
   typedef struct packed {
      logic [31:0] now_ms;
      logic [15:0] voltage_mv;
      logic        voltage_valid;
      logic        executor_running;
      logic [7:0]  running_program;
   } item_type;

   // One result beat
   typedef struct packed {
      logic       start_request;
      logic       stop_request;
      logic [7:0] attempts_used;
      logic       low_pending;
   } result_type;

   // Turn a seconds setting into milliseconds
   function automatic logic [31:0] sec_to_ms(input logic [15:0] sec);
      logic [25:0] prod;
      prod = 26'(sec) * 26'(MS_PER_SEC);
      return 32'(prod);
   endfunction

endpackage

// File: src/lvrs_req_if.sv
interface lvrs_req_if;

   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic [15:0] voltage_mv;
   logic        voltage_valid;
   logic        executor_running;
   logic [7:0]  running_program;

   modport source (
      output valid, now_ms, voltage_mv, voltage_valid, executor_running, running_program,
      input  ready
   );

   modport sink (
      input  valid, now_ms, voltage_mv, voltage_valid, executor_running, running_program,
      output ready
   );

endinterface

// File: src/lvrs_rsp_if.sv
interface lvrs_rsp_if;

   logic       valid;
   logic       ready;
   logic       start_request;
   logic       stop_request;
   logic [7:0] attempts_used;
   logic       low_pending;

   modport source (
      output valid, start_request, stop_request, attempts_used, low_pending,
      input  ready
   );

   modport sink (
      input  valid, start_request, stop_request, attempts_used, low_pending,
      output ready
   );

endinterface

// File: src/lvrs_core.sv
module lvrs_core #(
   parameter logic [31:0] DAY_LENGTH_MS = 32'd86400000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  lvrs_pkg::cfg_type    cfg,
   input  lvrs_pkg::item_type   item,
   output lvrs_pkg::result_type result
);

   import lvrs_pkg::*;

   logic [31:0] day_start_ff,  day_start_in;
   logic        day_valid_ff,  day_valid_in;
   logic [7:0]  attempts_ff,   attempts_in;
   logic [31:0] last_try_ff,   last_try_in;
   logic [31:0] low_since_ff,  low_since_in;
   logic        timer_on_ff,   timer_on_in;

   logic [31:0] day_base;
   logic [31:0] since_base;
   logic        timer_base;
   logic [16:0] clear_level;
   logic        start_req;
   logic        stop_req;

   // Decision for one sample, following the priority of the checks
   always_comb begin
      day_start_in = day_start_ff;
      day_valid_in = day_valid_ff;
      attempts_in  = attempts_ff;
      last_try_in  = last_try_ff;
      low_since_in = low_since_ff;
      timer_on_in  = timer_on_ff;
      start_req    = 1'b0;
      stop_req     = 1'b0;
      clear_level  = 17'(cfg.start_mv) + 17'(cfg.hysteresis_mv);

      // The day window opens at the first enabled beat
      day_base   = day_valid_ff ? day_start_ff : item.now_ms;
      since_base = timer_on_ff ? low_since_ff : item.now_ms;
      timer_base = 1'b1;

      if (!cfg.enabled) begin
         timer_on_in = 1'b0;
      end else begin
         day_valid_in = 1'b1;
         day_start_in = day_base;
         if (32'(item.now_ms - day_base) >= DAY_LENGTH_MS) begin
            attempts_in  = '0;
            day_start_in = item.now_ms;
         end

         if (item.voltage_valid) begin
            if (item.voltage_mv < cfg.abort_mv) begin
               timer_on_in = 1'b0;
               stop_req    = (cfg.program_number != '0) && item.executor_running &&
                             (item.running_program == cfg.program_number);
            end else if (item.voltage_mv < cfg.start_mv) begin
               // Low timer runs; a matured timer asks for a start if allowed
               timer_on_in  = timer_base;
               low_since_in = since_base;
               if (32'(item.now_ms - since_base) >= cfg.min_low_ms) begin
                  if ((attempts_in < cfg.max_attempts) &&
                      (32'(item.now_ms - last_try_ff) >= cfg.min_gap_ms)) begin
                     if (cfg.program_number != '0) begin
                        start_req   = 1'b1;
                        attempts_in = attempts_in + 8'd1;
                        last_try_in = item.now_ms;
                     end
                     timer_on_in = 1'b0;
                  end
               end
            end else if (17'(item.voltage_mv) > clear_level) begin
               timer_on_in = 1'b0;
            end
         end
      end

      result.start_request = start_req;
      result.stop_request  = stop_req;
      result.attempts_used = attempts_in;
      result.low_pending   = timer_on_in;
   end

   // Supervisor state advances once per sample beat
   always_ff @(posedge clock) begin
      if (reset) begin
         day_start_ff <= '0;
         day_valid_ff <= 1'b0;
         attempts_ff  <= '0;
         last_try_ff  <= '0;
         low_since_ff <= '0;
         timer_on_ff  <= 1'b0;
      end else if (step) begin
         day_start_ff <= day_start_in;
         day_valid_ff <= day_valid_in;
         attempts_ff  <= attempts_in;
         last_try_ff  <= last_try_in;
         low_since_ff <= low_since_in;
         timer_on_ff  <= timer_on_in;
      end
   end

endmodule

// File: src/low_voltage_recovery_supervisor_top.sv
// Channel   Direction  Handshake      Carries
// req_bus   in         valid / ready  now_ms, voltage_mv, voltage_valid, executor_running,
//                                     running_program
// rsp_bus   out        valid / ready  start_request, stop_request, attempts_used, low_pending
// csr_*     in         csr_we only    csr_index, csr_wdata
//
// A sample beat is registered in the input register, evaluated by the core from there and its
// result is held in the output register until it is taken.
// One sample is accepted every cycle while results are being taken; the throughput is set
// by the single evaluation stage, which updates the supervisor state once per beat.
// A stalled result holds the evaluation stage, which in turn holds the input register.
// Synchronous reset clears the pipeline, the supervisor state and the registers to defaults.
module low_voltage_recovery_supervisor_top #(
   parameter logic [31:0] DAY_LENGTH_MS = 32'd86400000
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lvrs_req_if.sink                              req_bus,
   lvrs_rsp_if.source                            rsp_bus,
   input  logic                                  csr_we,
   input  logic [lvrs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lvrs_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import lvrs_pkg::*;

   cfg_type    cfg_ff;
   logic       stage_valid_ff;
   item_type   stage_item_ff;
   logic       out_valid_ff;
   result_type out_result_ff;
   result_type core_result;
   logic       advance;
   logic       take_req;
   logic       step;

   // Configuration registers, durations stored in milliseconds
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled        <= 1'b0;
         cfg_ff.start_mv       <= START_MV_RESET;
         cfg_ff.abort_mv       <= ABORT_MV_RESET;
         cfg_ff.hysteresis_mv  <= HYSTERESIS_RESET;
         cfg_ff.min_low_ms     <= sec_to_ms(MIN_LOW_SEC_RESET);
         cfg_ff.max_attempts   <= MAX_ATTEMPTS_RESET;
         cfg_ff.min_gap_ms     <= sec_to_ms(MIN_GAP_SEC_RESET);
         cfg_ff.program_number <= PROGRAM_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_ENABLED:      cfg_ff.enabled        <= csr_wdata[0];
            REG_START_MV:     cfg_ff.start_mv       <= csr_wdata;
            REG_ABORT_MV:     cfg_ff.abort_mv       <= csr_wdata;
            REG_HYSTERESIS:   cfg_ff.hysteresis_mv  <= csr_wdata;
            REG_MIN_LOW_SEC:  cfg_ff.min_low_ms     <= sec_to_ms(csr_wdata);
            REG_MAX_ATTEMPTS: cfg_ff.max_attempts   <= csr_wdata[7:0];
            REG_MIN_GAP_SEC:  cfg_ff.min_gap_ms     <= sec_to_ms(csr_wdata);
            REG_PROGRAM:      cfg_ff.program_number <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline flow control
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !stage_valid_ff || advance;
   assign take_req      = req_bus.valid && req_bus.ready;
   assign step          = stage_valid_ff && advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         stage_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         stage_item_ff.now_ms           <= req_bus.now_ms;
         stage_item_ff.voltage_mv       <= req_bus.voltage_mv;
         stage_item_ff.voltage_valid    <= req_bus.voltage_valid;
         stage_item_ff.executor_running <= req_bus.executor_running;
         stage_item_ff.running_program  <= req_bus.running_program;
      end
   end

   lvrs_core #(
      .DAY_LENGTH_MS (DAY_LENGTH_MS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg_ff),
      .item   (stage_item_ff),
      .result (core_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.start_request = out_result_ff.start_request;
   assign rsp_bus.stop_request  = out_result_ff.stop_request;
   assign rsp_bus.attempts_used = out_result_ff.attempts_used;
   assign rsp_bus.low_pending   = out_result_ff.low_pending;

endmodule
